// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

// ----- hdl/bmmcr_pkg.sv -----
package bmmcr_pkg;
  localparam int unsigned CfgWidth = 5;
  localparam int unsigned CfgIdxWidth = 2;
  localparam logic [CfgIdxWidth-1:0] RegBlockWidth = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegBlockHeight = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegReduceMode = 2'd2;
  localparam logic [4:0] DimMax = 5'd16;

  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
  } pixel_t;

  typedef enum logic [2:0] {
    StIdle, StDivInit, StDiv, StMedInit, StMedScan, StMedNext, StOut
  } state_e;

  // Division unit control and status.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

// ----- hdl/bmmcr_if.sv -----
interface bmmcr_pix_if;
  import bmmcr_pkg::*;
  logic valid;
  logic ready;
  logic [7:0] chan0_in;
  logic [7:0] chan1_in;
  logic [7:0] chan2_in;
  modport source (output valid, chan0_in, chan1_in, chan2_in, input ready);
  modport sink (input valid, chan0_in, chan1_in, chan2_in, output ready);
endinterface

interface bmmcr_res_if;
  logic valid;
  logic ready;
  logic [7:0] chan0_out;
  logic [7:0] chan1_out;
  logic [7:0] chan2_out;
  logic [23:0] color_index;
  modport source (output valid, chan0_out, chan1_out, chan2_out, color_index, input ready);
  modport sink (input valid, chan0_out, chan1_out, chan2_out, color_index, output ready);
endinterface

// ----- hdl/bmmcr_div.sv -----
// Restoring divider, one quotient bit per cycle, with round-half-even and
// saturation to a byte.
module bmmcr_div import bmmcr_pkg::*; #(
  parameter int unsigned NW = 16,
  parameter int unsigned DW = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output div_ctl_t      ctl_o,
  output logic [7:0]    res_o
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [DW:0] trial;
  logic [DW+1:0] rem2;
  logic [NW:0] qr;

  always_comb begin
    trial = {rem_q[DW-1:0], quo_q[NW-1]};
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; cnt_d = CW'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  always_comb begin
    rem2 = {rem_q, 1'b0};
    qr = {1'b0, quo_q};
    if (rem2 > {2'b0, den_q} || (rem2 == {2'b0, den_q} && quo_q[0])) qr = qr + 1'b1;
    res_o = (qr > (NW+1)'(255)) ? 8'hFF : qr[7:0];
  end

  assign ctl_o = '{start: start_i, busy: busy_q, done: done_q};

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_no_restart, clk_i, rst_ni, start_i && busy_q, "divider restarted while busy")
  `ASSERT_IMPL(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q), "done without busy")
  `ASSERT_NEVER(a_done_busy, clk_i, rst_ni, done_q && busy_q, "done and busy together")
endmodule

// ----- hdl/block_mean_median_color_reducer.sv -----
// Accepts one pixel per cycle while collecting; the pixel that completes a block
// starts the reduction and the block is not ready until its result is taken.
// Mean: the three channel sums go in turn through one shared serial divider.
// Median: per channel, candidate values are tried upward from 0 with one scan of
// the pixel store per candidate value; the result waits in a register.
// Active-low async reset clears state, channel, sums and count; store undefined.
module block_mean_median_color_reducer import bmmcr_pkg::*; #(
  parameter int unsigned MAX_BLOCK_PIXELS = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgWidth-1:0]     cfg_data_i,
  bmmcr_pix_if.sink               pix,
  bmmcr_res_if.source             res
);
  localparam int unsigned AW = (MAX_BLOCK_PIXELS > 1) ? $clog2(MAX_BLOCK_PIXELS) : 1;
  localparam int unsigned NCW = $clog2(MAX_BLOCK_PIXELS + 2);
  localparam int unsigned SW = 8 + NCW;

  logic [4:0] bw_q, bh_q;
  logic mode_q;
  state_e st_q, st_d;
  logic [NCW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] sum_q [3], sum_d [3];
  logic [1:0] ch_q, ch_d;
  logic [7:0] val_q, val_d;
  logic [NCW-1:0] scan_q, scan_d, cum_q, cum_d;
  logic rd_pend_q;
  logic [7:0] r_q [3], r_d [3];

  pixel_t mem [MAX_BLOCK_PIXELS];
  pixel_t rd_q;
  logic [AW-1:0] rd_addr;

  logic [4:0] w_c, h_c;
  logic [9:0] tgt_raw;
  logic [NCW-1:0] tgt;
  logic acc;
  logic [NCW-1:0] cnt_inc;
  div_ctl_t dctl;
  logic dstart;
  logic [7:0] dres;
  logic [SW-1:0] dnum;
  logic [7:0] rd_ch;
  logic [NCW-1:0] stored;
  logic med_hit;

  always_comb begin
    w_c = (bw_q == 5'd0) ? 5'd1 : (bw_q > DimMax) ? DimMax : bw_q;
    h_c = (bh_q == 5'd0) ? 5'd1 : (bh_q > DimMax) ? DimMax : bh_q;
    tgt_raw = {5'd0, w_c} * {5'd0, h_c};
    tgt = (32'(tgt_raw) > MAX_BLOCK_PIXELS) ? NCW'(MAX_BLOCK_PIXELS) : NCW'(tgt_raw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= 5'd4; bh_q <= 5'd4; mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBlockWidth:  bw_q <= cfg_data_i;
        RegBlockHeight: bh_q <= cfg_data_i;
        RegReduceMode:  mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign pix.ready = (st_q == StIdle);
  assign acc = pix.valid && pix.ready;
  assign cnt_inc = cnt_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (acc && 32'(cnt_q) < MAX_BLOCK_PIXELS)
      mem[cnt_q[AW-1:0]] <= '{c0: pix.chan0_in, c1: pix.chan1_in, c2: pix.chan2_in};
    rd_q <= mem[rd_addr];
  end
  assign rd_addr = scan_q[AW-1:0];
  assign stored = (32'(cnt_q) > MAX_BLOCK_PIXELS) ? NCW'(MAX_BLOCK_PIXELS) : cnt_q;

  always_comb begin
    unique case (ch_q)
      2'd0: rd_ch = rd_q.c0;
      2'd1: rd_ch = rd_q.c1;
      default: rd_ch = rd_q.c2;
    endcase
  end

  // The running count covers every value up to the candidate, so the first
  // candidate whose count passes half the block is the upper median.
  assign med_hit = (cum_q > (cnt_q >> 1)) || (val_q == 8'hFF);

  assign dnum = sum_q[ch_q];
  assign dstart = (st_q == StDivInit);

  bmmcr_div #(.NW(SW), .DW(NCW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(cnt_q),
    .ctl_o(dctl), .res_o(dres)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (acc && cnt_inc >= tgt) st_d = mode_q ? StMedInit : StDivInit;
      StDivInit: st_d = StDiv;
      StDiv: if (dctl.done) st_d = (ch_q == 2'd2) ? StOut : StDivInit;
      StMedInit: st_d = StMedScan;
      StMedScan: if (scan_q == stored && !rd_pend_q) st_d = StMedNext;
      StMedNext: st_d = (med_hit && ch_q == 2'd2) ? StOut : StMedScan;
      StOut: if (res.ready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q; ch_d = ch_q; val_d = val_q; scan_d = scan_q; cum_d = cum_q;
    for (int i = 0; i < 3; i++) begin
      sum_d[i] = sum_q[i]; r_d[i] = r_q[i];
    end
    unique case (st_q)
      StIdle: begin
        if (acc) begin
          cnt_d = cnt_inc;
          sum_d[0] = sum_q[0] + SW'(pix.chan0_in);
          sum_d[1] = sum_q[1] + SW'(pix.chan1_in);
          sum_d[2] = sum_q[2] + SW'(pix.chan2_in);
        end
        ch_d = 2'd0;
      end
      StDivInit: ;
      StDiv: if (dctl.done) begin
        r_d[ch_q] = dres;
        ch_d = ch_q + 2'd1;
      end
      StMedInit: begin
        val_d = 8'd0; scan_d = '0; cum_d = '0;
      end
      StMedScan: begin
        if (rd_pend_q && rd_ch == val_q) cum_d = cum_q + 1'b1;
        if (scan_q != stored) scan_d = scan_q + 1'b1;
      end
      StMedNext: begin
        scan_d = '0;
        if (med_hit) begin
          r_d[ch_q] = val_q; cum_d = '0; val_d = 8'd0;
          ch_d = ch_q + 2'd1;
        end else begin
          val_d = val_q + 8'd1;
        end
      end
      StOut: if (res.ready) begin
        cnt_d = '0;
        for (int i = 0; i < 3; i++) sum_d[i] = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; ch_q <= '0; rd_pend_q <= 1'b0;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d; ch_q <= (ch_d == 2'd3) ? 2'd2 : ch_d;
      rd_pend_q <= (st_q == StMedScan) && (scan_q != stored);
      for (int i = 0; i < 3; i++) sum_q[i] <= sum_d[i];
    end
  end
  always_ff @(posedge clk_i) begin
    val_q <= val_d; scan_q <= scan_d; cum_q <= cum_d;
    for (int i = 0; i < 3; i++) r_q[i] <= r_d[i];
  end

  assign res.valid = (st_q == StOut);
  assign res.chan0_out = r_q[0];
  assign res.chan1_out = r_q[1];
  assign res.chan2_out = r_q[2];
  assign res.color_index = {r_q[0], r_q[1], r_q[2]};

  `include "assert_macros.svh"
  `ASSERT_NEVER(a_ready_busy, clk_i, rst_ni, pix.ready && res.valid, "ready while result pending")
  `ASSERT_IMPL(a_div_only, clk_i, rst_ni, dctl.busy |-> (st_q == StDiv), "divider busy outside divide")
  `ASSERT_IMPL(a_clear, clk_i, rst_ni, (res.valid && res.ready) |=> (cnt_q == '0), "count not cleared")
endmodule
